// ----- src/rttr_pkg.sv -----
// ----------------------------------------------------------------------------
// rttr_pkg: request timeout/retry tracker shared definitions
// Slot and event types, command and event codes, register map.
// ----------------------------------------------------------------------------
package rttr_pkg;

  localparam int Slots   = 16;
  localparam int CntW    = $clog2(Slots + 1);
  localparam int StepW   = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int IdW     = 32;
  localparam int RetryW  = 8;
  localparam int TicksW  = 31;
  localparam int PendW   = 5;
  localparam int PaddrW  = 3;
  localparam int PdataW  = 32;

  localparam logic [TicksW-1:0] TimeoutReset = TicksW'(1000);
  localparam logic [RetryW-1:0] RetryReset   = '0;

  // register word index (paddr[2])
  localparam logic RegTimeout    = 1'b0;
  localparam logic RegMaxRetries = 1'b1;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_ISSUE = 2'd1,
    CMD_REPLY = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    EV_ISSUED    = 3'd0,
    EV_RESEND    = 3'd1,
    EV_TIMEOUT   = 3'd2,
    EV_REPLY_OK  = 3'd3,
    EV_REPLY_ERR = 3'd4,
    EV_UNKNOWN   = 3'd5,
    EV_FULL      = 3'd6,
    EV_CANCEL    = 3'd7
  } ev_e;

  typedef struct packed {
    logic              valid;
    logic [IdW-1:0]    id;
    logic [RetryW-1:0] retries;
    logic [TicksW-1:0] remaining;
  } slot_t;

  typedef struct packed {
    ev_e            res;
    logic [IdW-1:0] id;
    logic [IdW-1:0] err;
  } ev_t;

  typedef struct packed {
    slot_t slot;
    logic  ev_v;
    ev_t   ev;
    logic  take;   // issue placed or reply matched
    logic  alloc;
    logic  freed;
  } proc_t;

endpackage

// ----- src/request_timeout_retry_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// request_timeout_retry_tracker_unit: outstanding request timeout/retry tracker
// Ring of slot cells rotated through one update unit, one slot per cycle while the output keeps up.
// ----------------------------------------------------------------------------
// Each command makes one full turn of the slot ring, one slot per cycle while
// the output keeps up; a new command is accepted only back in idle, after the
// turn and its flush. An event waits in a hold register until the next one is
// found, then moves to the output register; the last one moves out once the
// turn ends. Reset clears all slot valid bits, the live count, the id counter
// and the result pipeline, loads defaults.
module request_timeout_retry_tracker_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rttr_pkg::PaddrW-1:0]   paddr,
  input  logic [rttr_pkg::PdataW-1:0]   pwdata,
  output logic [rttr_pkg::PdataW-1:0]   prdata,
  output logic                          pready,
  // commands
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [63:0]                   s_axis_tdata,  // request_id, status_code
  input  logic [1:0]                    s_axis_tuser,  // cmd
  // events
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [71:0]                   m_axis_tdata,  // event_id, err_status, pending_count
  output logic [2:0]                    m_axis_tuser,  // event_res
  output logic                          m_axis_tlast
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PASS,
    ST_FLUSH
  } state_e;

  localparam logic [rttr_pkg::StepW-1:0] LastStep = rttr_pkg::StepW'(rttr_pkg::Slots - 1);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [rttr_pkg::TicksW-1:0] timeout_q;
  logic [rttr_pkg::RetryW-1:0] max_retries_q;
  logic                        reg_idx;

  assign reg_idx = paddr[2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q     <= rttr_pkg::TimeoutReset;
      max_retries_q <= rttr_pkg::RetryReset;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        rttr_pkg::RegTimeout:    timeout_q     <= pwdata[rttr_pkg::TicksW-1:0];
        rttr_pkg::RegMaxRetries: max_retries_q <= pwdata[rttr_pkg::RetryW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rttr_pkg::RegTimeout:    prdata = rttr_pkg::PdataW'(timeout_q);
      rttr_pkg::RegMaxRetries: prdata = rttr_pkg::PdataW'(max_retries_q);
      default:                 prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // control and result pipeline registers
  // --------------------------------------------------------------------------
  state_e                       state_q;
  rttr_pkg::cmd_e               cmd_q;
  logic [rttr_pkg::IdW-1:0]     rid_q;
  logic [rttr_pkg::IdW-1:0]     status_q;
  logic [rttr_pkg::StepW-1:0]   step_q;
  logic                         done_q;
  logic [rttr_pkg::CntW-1:0]    cnt_q;
  logic [rttr_pkg::IdW-1:0]     next_id_q;
  logic                         hold_v_q;
  rttr_pkg::ev_t                hold_ev_q;
  logic [rttr_pkg::CntW-1:0]    hold_cnt_q;
  logic                         out_v_q;
  rttr_pkg::ev_t                out_ev_q;
  logic [rttr_pkg::CntW-1:0]    out_cnt_q;
  logic                         out_last_q;

  // --------------------------------------------------------------------------
  // slot ring: cell i takes cell i+1, the last cell takes the updated head
  // --------------------------------------------------------------------------
  rttr_pkg::slot_t cell_out [rttr_pkg::Slots];
  rttr_pkg::slot_t cell_in  [rttr_pkg::Slots];
  rttr_pkg::proc_t proc;
  logic            out_free;
  logic            adv;
  logic            shift;
  logic            miss;
  logic            out_load;
  logic [rttr_pkg::CntW-1:0] cnt_d;

  for (genvar i = 0; i < rttr_pkg::Slots; i++) begin : g_cell
    if (i == rttr_pkg::Slots - 1) begin : g_tail
      assign cell_in[i] = proc.slot;
    end else begin : g_mid
      assign cell_in[i] = cell_out[i+1];
    end
    rttr_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .slot_i (cell_in[i]),
      .slot_o (cell_out[i])
    );
  end

  rttr_slot_proc u_proc (
    .cmd_i        (cmd_q),
    .rid_i        (rid_q),
    .status_i     (status_q),
    .done_i       (done_q),
    .timeout_i    (timeout_q),
    .max_retries_i(max_retries_q),
    .next_id_i    (next_id_q),
    .slot_i       (cell_out[0]),
    .proc_o       (proc)
  );

  assign out_free = !out_v_q || m_axis_tready;
  // a second event while one is held needs the output register free
  assign adv      = !(proc.ev_v && hold_v_q && !out_free);
  assign shift    = (state_q == ST_PASS) && adv;
  assign cnt_d    = cnt_q + rttr_pkg::CntW'(proc.alloc) - rttr_pkg::CntW'(proc.freed);
  // issue with no free slot, or reply with no matching id
  assign miss     = !done_q &&
                    ((cmd_q == rttr_pkg::CMD_ISSUE) || (cmd_q == rttr_pkg::CMD_REPLY));
  // held event moves out when a newer one arrives or the turn ends
  assign out_load = ((state_q == ST_PASS) && adv && proc.ev_v && hold_v_q) ||
                    ((state_q == ST_FLUSH) && !miss && hold_v_q && out_free);

  assign s_axis_tready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cmd_q      <= rttr_pkg::CMD_TICK;
      rid_q      <= '0;
      status_q   <= '0;
      step_q     <= '0;
      done_q     <= 1'b0;
      cnt_q      <= '0;
      next_id_q  <= '0;
      hold_v_q   <= 1'b0;
      hold_ev_q  <= '0;
      hold_cnt_q <= '0;
      out_v_q    <= 1'b0;
      out_ev_q   <= '0;
      out_cnt_q  <= '0;
      out_last_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            cmd_q    <= rttr_pkg::cmd_e'(s_axis_tuser);
            rid_q    <= s_axis_tdata[31:0];
            status_q <= s_axis_tdata[63:32];
            step_q   <= '0;
            done_q   <= 1'b0;
            state_q  <= ST_PASS;
          end
        end
        ST_PASS: begin
          if (adv) begin
            step_q    <= step_q + rttr_pkg::StepW'(1);
            cnt_q     <= cnt_d;
            done_q    <= done_q | proc.take;
            if (proc.alloc) begin
              next_id_q <= next_id_q + rttr_pkg::IdW'(1);
            end
            if (proc.ev_v) begin
              if (hold_v_q) begin
                out_ev_q   <= hold_ev_q;
                out_cnt_q  <= hold_cnt_q;
                out_last_q <= 1'b0;
              end
              hold_v_q   <= 1'b1;
              hold_ev_q  <= proc.ev;
              hold_cnt_q <= cnt_d;
            end
            if (step_q == LastStep) begin
              state_q <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          if (miss) begin
            done_q     <= 1'b1;
            hold_v_q   <= 1'b1;
            hold_cnt_q <= cnt_q;
            hold_ev_q.err <= '0;
            if (cmd_q == rttr_pkg::CMD_ISSUE) begin
              hold_ev_q.res <= rttr_pkg::EV_FULL;
              hold_ev_q.id  <= '0;
            end else begin
              hold_ev_q.res <= rttr_pkg::EV_UNKNOWN;
              hold_ev_q.id  <= rid_q;
            end
          end else if (hold_v_q) begin
            if (out_free) begin
              out_ev_q   <= hold_ev_q;
              out_cnt_q  <= hold_cnt_q;
              out_last_q <= 1'b1;
              hold_v_q   <= 1'b0;
              state_q    <= ST_IDLE;
            end
          end else begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_ev_q.res;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {3'b000, rttr_pkg::PendW'(out_cnt_q), out_ev_q.err, out_ev_q.id};

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= rttr_pkg::CntW'(rttr_pkg::Slots))
    else $error("live count above slot count");

  a_hold_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_v_q |-> (state_q != ST_IDLE))
    else $error("held event left behind in idle");

  a_idle_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |=> $stable(cnt_q))
    else $error("live count changed outside a pass");

  a_pass_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PASS && step_q == LastStep && adv) |=> (state_q == ST_FLUSH))
    else $error("pass did not end after the last slot");
`endif

endmodule

// ----- src/rttr_cell.sv -----
// ----------------------------------------------------------------------------
// rttr_cell: one slot of the tracker ring
// Holds one entry and takes its neighbor's entry on every shift.
// ----------------------------------------------------------------------------
module rttr_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  rttr_pkg::slot_t slot_i,
  output rttr_pkg::slot_t slot_o
);

  logic                        valid_q;
  logic [rttr_pkg::IdW-1:0]    id_q;
  logic [rttr_pkg::RetryW-1:0] retries_q;
  logic [rttr_pkg::TicksW-1:0] remaining_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= slot_i.valid;
    end
  end

  // payload is only meaningful while valid
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      id_q        <= slot_i.id;
      retries_q   <= slot_i.retries;
      remaining_q <= slot_i.remaining;
    end
  end

  always_comb begin
    slot_o.valid     = valid_q;
    slot_o.id        = id_q;
    slot_o.retries   = retries_q;
    slot_o.remaining = remaining_q;
  end

endmodule

// ----- src/rttr_slot_proc.sv -----
// ----------------------------------------------------------------------------
// rttr_slot_proc: per-slot update unit at the head of the ring
// Applies the current command to the entry leaving cell 0.
// ----------------------------------------------------------------------------
module rttr_slot_proc (
  input  rttr_pkg::cmd_e                  cmd_i,
  input  logic [rttr_pkg::IdW-1:0]        rid_i,
  input  logic [rttr_pkg::IdW-1:0]        status_i,
  input  logic                            done_i,
  input  logic [rttr_pkg::TicksW-1:0]     timeout_i,
  input  logic [rttr_pkg::RetryW-1:0]     max_retries_i,
  input  logic [rttr_pkg::IdW-1:0]        next_id_i,
  input  rttr_pkg::slot_t                 slot_i,
  output rttr_pkg::proc_t                 proc_o
);

  logic [rttr_pkg::IdW-1:0] new_id;

  assign new_id = next_id_i + rttr_pkg::IdW'(1);

  always_comb begin
    proc_o        = '0;
    proc_o.slot   = slot_i;
    proc_o.ev.res = rttr_pkg::EV_ISSUED;
    unique case (cmd_i)
      rttr_pkg::CMD_TICK: begin
        if (slot_i.valid) begin
          // a count of 0 or 1 expires
          if (slot_i.remaining > rttr_pkg::TicksW'(1)) begin
            proc_o.slot.remaining = slot_i.remaining - rttr_pkg::TicksW'(1);
          end else if (slot_i.retries < max_retries_i) begin
            proc_o.slot.retries   = slot_i.retries + rttr_pkg::RetryW'(1);
            proc_o.slot.remaining = timeout_i;
            proc_o.ev_v           = 1'b1;
            proc_o.ev.res         = rttr_pkg::EV_RESEND;
            proc_o.ev.id          = slot_i.id;
          end else begin
            proc_o.slot.valid = 1'b0;
            proc_o.freed      = 1'b1;
            proc_o.ev_v       = 1'b1;
            proc_o.ev.res     = rttr_pkg::EV_TIMEOUT;
            proc_o.ev.id      = slot_i.id;
          end
        end
      end
      rttr_pkg::CMD_ISSUE: begin
        if (!slot_i.valid && !done_i) begin
          proc_o.slot.valid     = 1'b1;
          proc_o.slot.id        = new_id;
          proc_o.slot.retries   = '0;
          proc_o.slot.remaining = timeout_i;
          proc_o.take           = 1'b1;
          proc_o.alloc          = 1'b1;
          proc_o.ev_v           = 1'b1;
          proc_o.ev.res         = rttr_pkg::EV_ISSUED;
          proc_o.ev.id          = new_id;
        end
      end
      rttr_pkg::CMD_REPLY: begin
        if (slot_i.valid && !done_i && (slot_i.id == rid_i)) begin
          proc_o.slot.valid = 1'b0;
          proc_o.take       = 1'b1;
          proc_o.freed      = 1'b1;
          proc_o.ev_v       = 1'b1;
          proc_o.ev.id      = rid_i;
          if (status_i == '0) begin
            proc_o.ev.res = rttr_pkg::EV_REPLY_OK;
          end else begin
            proc_o.ev.res = rttr_pkg::EV_REPLY_ERR;
            proc_o.ev.err = status_i;
          end
        end
      end
      rttr_pkg::CMD_CLEAR: begin
        if (slot_i.valid) begin
          proc_o.slot.valid = 1'b0;
          proc_o.freed      = 1'b1;
          proc_o.ev_v       = 1'b1;
          proc_o.ev.res     = rttr_pkg::EV_CANCEL;
          proc_o.ev.id      = slot_i.id;
          proc_o.ev.err     = status_i;
        end
      end
    endcase
  end

endmodule

// ----- tb/request_timeout_retry_tracker_unit_test.sv -----
// ----------------------------------------------------------------------------
// request_timeout_retry_tracker_unit_test: self-checking bench for the tracker
// Command beats go in bursts with random gaps, event beats are taken on a
// shifting stall pattern. A behavioral slot table predicts every event, and
// each event beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module request_timeout_retry_tracker_unit_test;

  localparam int ClkPeriod  = 12;
  localparam int SettleCyc  = 2 * rttr_pkg::Slots + 8;  // a quiet turn plus the result pipe
  localparam int StallLimit = 2000;
  localparam int RandItems  = 450;
  localparam int NumPhases  = 8;

  typedef struct {
    rttr_pkg::ev_e                  res;
    logic [rttr_pkg::IdW-1:0]       id;
    logic [rttr_pkg::IdW-1:0]       err;
    logic [rttr_pkg::PendW-1:0]     pend;
    logic                           last;
  } evt_t;

  typedef enum logic {ROW_BEAT, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e      kind;
    rttr_pkg::cmd_e cmd;
    logic [31:0]    a;      // request_id, or register index
    logic [31:0]    b;      // status_code, or register value
    int             reps;
    logic           typed;
    evt_t           exp_ev;
  } row_t;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          psel          = 1'b0;
  logic                          penable       = 1'b0;
  logic                          pwrite        = 1'b0;
  logic [rttr_pkg::PaddrW-1:0]   paddr         = '0;
  logic [rttr_pkg::PdataW-1:0]   pwdata        = '0;
  logic [rttr_pkg::PdataW-1:0]   prdata;
  logic                          pready;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [63:0]                   s_axis_tdata  = '0;  // request_id, status_code
  logic [1:0]                    s_axis_tuser  = '0;  // cmd
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [71:0]                   m_axis_tdata;        // event_id, err_status, pending_count
  logic [2:0]                    m_axis_tuser;        // event_res
  logic                          m_axis_tlast;

  // behavioral slot table
  logic                          slot_live    [rttr_pkg::Slots];
  logic [rttr_pkg::IdW-1:0]      slot_req_id  [rttr_pkg::Slots];
  logic [rttr_pkg::RetryW-1:0]   slot_resends [rttr_pkg::Slots];
  logic [rttr_pkg::TicksW-1:0]   slot_left    [rttr_pkg::Slots];
  logic [rttr_pkg::IdW-1:0]      id_counter;
  logic [rttr_pkg::TicksW-1:0]   cfg_timeout;
  logic [rttr_pkg::RetryW-1:0]   cfg_max_retries;

  evt_t expected_events[$];
  evt_t step_events[$];
  row_t directed_rows[$];

  int       errors      = 0;
  int       burst_left  = 0;
  int       idle_cycles = 0;
  int       stall_left  = 0;
  logic [2:0] stall_phase   = '0;
  logic [7:0] stall_pattern = 8'hFF;

  request_timeout_retry_tracker_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
  endtask

  function automatic logic [rttr_pkg::PendW-1:0] live_slots();
    int n;
    n = 0;
    for (int i = 0; i < rttr_pkg::Slots; i++) n += slot_live[i] ? 1 : 0;
    return rttr_pkg::PendW'(n);
  endfunction

  function automatic void note_event(rttr_pkg::ev_e res, logic [rttr_pkg::IdW-1:0] id,
                                     logic [rttr_pkg::IdW-1:0] err);
    evt_t e;
    e.res  = res;
    e.id   = id;
    e.err  = err;
    e.pend = live_slots();
    e.last = 1'b0;
    step_events.insert(step_events.size(), e);
  endfunction

  // events one command causes, in order; updates the slot table
  function automatic void predict_tracker(rttr_pkg::cmd_e cmd, logic [rttr_pkg::IdW-1:0] rid,
                                          logic [rttr_pkg::IdW-1:0] status);
    logic done;
    done = 1'b0;
    step_events.delete();
    case (cmd)
      rttr_pkg::CMD_TICK: begin
        for (int i = 0; i < rttr_pkg::Slots; i++) begin
          if (slot_live[i]) begin
            if (slot_left[i] > 1) begin
              slot_left[i] = slot_left[i] - rttr_pkg::TicksW'(1);
            end else if (slot_resends[i] < cfg_max_retries) begin
              slot_resends[i] = slot_resends[i] + rttr_pkg::RetryW'(1);
              slot_left[i]    = cfg_timeout;
              note_event(rttr_pkg::EV_RESEND, slot_req_id[i], '0);
            end else begin
              slot_live[i] = 1'b0;
              note_event(rttr_pkg::EV_TIMEOUT, slot_req_id[i], '0);
            end
          end
        end
      end
      rttr_pkg::CMD_ISSUE: begin
        for (int i = 0; i < rttr_pkg::Slots; i++) begin
          if (!done && !slot_live[i]) begin
            id_counter      = id_counter + rttr_pkg::IdW'(1);
            slot_live[i]    = 1'b1;
            slot_req_id[i]  = id_counter;
            slot_resends[i] = '0;
            slot_left[i]    = cfg_timeout;
            note_event(rttr_pkg::EV_ISSUED, id_counter, '0);
            done = 1'b1;
          end
        end
        if (!done) note_event(rttr_pkg::EV_FULL, '0, '0);
      end
      rttr_pkg::CMD_REPLY: begin
        for (int i = 0; i < rttr_pkg::Slots; i++) begin
          if (!done && slot_live[i] && slot_req_id[i] == rid) begin
            slot_live[i] = 1'b0;
            if (status == '0) note_event(rttr_pkg::EV_REPLY_OK, rid, '0);
            else note_event(rttr_pkg::EV_REPLY_ERR, rid, status);
            done = 1'b1;
          end
        end
        if (!done) note_event(rttr_pkg::EV_UNKNOWN, rid, '0);
      end
      rttr_pkg::CMD_CLEAR: begin
        for (int i = 0; i < rttr_pkg::Slots; i++) begin
          if (slot_live[i]) begin
            slot_live[i] = 1'b0;
            note_event(rttr_pkg::EV_CANCEL, slot_req_id[i], status);
          end
        end
      end
    endcase
    if (step_events.size() > 0) begin
      step_events[step_events.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic void add_row(row_kind_e kind, rttr_pkg::cmd_e cmd, logic [31:0] a,
                                  logic [31:0] b, int reps);
    row_t r;
    r.kind  = kind;
    r.cmd   = cmd;
    r.a     = a;
    r.b     = b;
    r.reps  = reps;
    r.typed = 1'b0;
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  function automatic void add_typed(rttr_pkg::cmd_e cmd, logic [31:0] a, logic [31:0] b,
                                    rttr_pkg::ev_e res, logic [rttr_pkg::IdW-1:0] id,
                                    logic [rttr_pkg::IdW-1:0] err,
                                    logic [rttr_pkg::PendW-1:0] pend);
    row_t r;
    r.kind        = ROW_BEAT;
    r.cmd         = cmd;
    r.a           = a;
    r.b           = b;
    r.reps        = 1;
    r.typed       = 1'b1;
    r.exp_ev.res  = res;
    r.exp_ev.id   = id;
    r.exp_ev.err  = err;
    r.exp_ev.pend = pend;
    r.exp_ev.last = 1'b1;
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  // write a register, then read it back
  task automatic program_register(logic idx, logic [31:0] value);
    logic [rttr_pkg::PdataW-1:0] want;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == rttr_pkg::RegTimeout) cfg_timeout = value[rttr_pkg::TicksW-1:0];
    else cfg_max_retries = value[rttr_pkg::RetryW-1:0];
    want = (idx == rttr_pkg::RegTimeout) ? rttr_pkg::PdataW'(cfg_timeout)
                                         : rttr_pkg::PdataW'(cfg_max_retries);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) report_mismatch("register readback", 64'(prdata), 64'(want));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_cmd(rttr_pkg::cmd_e cmd, logic [31:0] rid, logic [31:0] status,
                          logic typed, evt_t typed_ev);
    int gap;
    int pick;
    if (burst_left == 0) begin
      pick = $urandom_range(7);
      if (pick < 2) gap = 0;
      else if (pick < 6) gap = $urandom_range(1, 4);
      else gap = $urandom_range(5, 24);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {status, rid};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_tracker(cmd, rid, status);
    if (typed) expected_events.insert(expected_events.size(), typed_ev);
    else foreach (step_events[k]) expected_events.insert(expected_events.size(), step_events[k]);
  endtask

  // hold off until every predicted event is out and the ring has come to rest
  task automatic drain_events();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
    burst_left = 0;
  endtask

  // receiver: a new 8-bit ready pattern every epoch, all ones now and then
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_left    = $urandom_range(20, 150);
      stall_pattern = ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
    end
    stall_left--;
    stall_phase = stall_phase + 3'd1;
    m_axis_tready <= stall_pattern[stall_phase];
  end

  always @(posedge clk_i) begin : event_check
    evt_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_events.size() == 0) begin
        report_mismatch("event with none pending, event_id", 64'(m_axis_tdata[31:0]), '0);
      end else begin
        want = expected_events.pop_front();
        if (m_axis_tuser !== want.res) begin
          report_mismatch("event_res", 64'(m_axis_tuser), 64'(want.res));
        end
        if (m_axis_tdata[31:0] !== want.id) begin
          report_mismatch("event_id", 64'(m_axis_tdata[31:0]), 64'(want.id));
        end
        if (m_axis_tdata[63:32] !== want.err) begin
          report_mismatch("err_status", 64'(m_axis_tdata[63:32]), 64'(want.err));
        end
        if (m_axis_tdata[68:64] !== want.pend) begin
          report_mismatch("pending_count", 64'(m_axis_tdata[68:64]), 64'(want.pend));
        end
        if (m_axis_tlast !== want.last) begin
          report_mismatch("last", 64'(m_axis_tlast), 64'(want.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    row_t           row;
    evt_t           no_ev;
    logic [31:0]    ticks_set [NumPhases];
    logic [31:0]    retry_set [NumPhases];
    int             live_idx[$];
    int             issue_pct;
    int             pick;
    rttr_pkg::cmd_e cmd;
    logic [31:0]    rid;
    logic [31:0]    status;

    foreach (slot_live[i]) begin
      slot_live[i]    = 1'b0;
      slot_req_id[i]  = '0;
      slot_resends[i] = '0;
      slot_left[i]    = '0;
    end
    id_counter      = '0;
    cfg_timeout     = rttr_pkg::TimeoutReset;
    cfg_max_retries = rttr_pkg::RetryReset;

    add_row(ROW_BEAT, rttr_pkg::CMD_TICK, '0, '0, 1);            // empty table: no event
    add_typed(rttr_pkg::CMD_REPLY, '0, '0, rttr_pkg::EV_UNKNOWN, '0, '0, 5'd0);
    add_typed(rttr_pkg::CMD_REPLY, '1, '1, rttr_pkg::EV_UNKNOWN, '1, '0, 5'd0);
    add_row(ROW_BEAT, rttr_pkg::CMD_CLEAR, '0, 32'h1234_5678, 1); // nothing to cancel
    add_typed(rttr_pkg::CMD_ISSUE, '1, '1, rttr_pkg::EV_ISSUED, 1, '0, 5'd1);
    add_typed(rttr_pkg::CMD_ISSUE, '0, '0, rttr_pkg::EV_ISSUED, 2, '0, 5'd2);
    add_typed(rttr_pkg::CMD_REPLY, 1, '0, rttr_pkg::EV_REPLY_OK, 1, '0, 5'd1);
    add_typed(rttr_pkg::CMD_REPLY, 2, '1, rttr_pkg::EV_REPLY_ERR, 2, '1, 5'd0);
    add_typed(rttr_pkg::CMD_REPLY, 2, '0, rttr_pkg::EV_UNKNOWN, 2, '0, 5'd0);  // already freed
    add_row(ROW_REG, rttr_pkg::CMD_TICK, 32'(rttr_pkg::RegTimeout), 1, 1);
    add_row(ROW_REG, rttr_pkg::CMD_TICK, 32'(rttr_pkg::RegMaxRetries), 1, 1);
    add_typed(rttr_pkg::CMD_ISSUE, '0, '0, rttr_pkg::EV_ISSUED, 3, '0, 5'd1);
    add_typed(rttr_pkg::CMD_ISSUE, '0, '0, rttr_pkg::EV_ISSUED, 4, '0, 5'd2);
    add_row(ROW_BEAT, rttr_pkg::CMD_TICK, '0, '0, 2);             // resend both, then time out
    add_row(ROW_REG, rttr_pkg::CMD_TICK, 32'(rttr_pkg::RegTimeout), 0, 1);  // zero acts as one
    add_typed(rttr_pkg::CMD_ISSUE, '0, '0, rttr_pkg::EV_ISSUED, 5, '0, 5'd1);
    add_row(ROW_BEAT, rttr_pkg::CMD_TICK, '0, '0, 2);
    add_row(ROW_REG, rttr_pkg::CMD_TICK, 32'(rttr_pkg::RegTimeout), 32'h7FFF_FFFF, 1);
    add_row(ROW_REG, rttr_pkg::CMD_TICK, 32'(rttr_pkg::RegMaxRetries), 32'hFF, 1);
    add_row(ROW_BEAT, rttr_pkg::CMD_ISSUE, '0, '0, rttr_pkg::Slots);
    add_typed(rttr_pkg::CMD_ISSUE, '0, '0, rttr_pkg::EV_FULL, '0, '0, 5'd16);
    add_row(ROW_BEAT, rttr_pkg::CMD_TICK, '0, '0, 1);             // long deadline: quiet
    add_typed(rttr_pkg::CMD_REPLY, 22, '0, rttr_pkg::EV_UNKNOWN, 22, '0, 5'd16); // no id taken
    add_row(ROW_BEAT, rttr_pkg::CMD_CLEAR, '0, 32'hFFFF_FFFF, 1);

    ticks_set = '{1, 2, 0, 5, 32'h7FFF_FFFF, 3, $urandom_range(1, 12), 1000};
    retry_set = '{0, 3, 255, 1, 0, 255, $urandom_range(0, 6), 2};

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      if (row.kind == ROW_REG) begin
        drain_events();
        program_register(row.a[0], row.b);
      end else begin
        repeat (row.reps) send_cmd(row.cmd, row.a, row.b, row.typed, row.exp_ev);
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      drain_events();
      program_register(rttr_pkg::RegTimeout, ticks_set[p]);
      program_register(rttr_pkg::RegMaxRetries, retry_set[p]);
      issue_pct = $urandom_range(20, 50);
      for (int n = 0; n < RandItems / NumPhases; n++) begin
        pick   = $urandom_range(99);
        rid    = $urandom();
        status = $urandom();
        if (pick < issue_pct) begin
          cmd = rttr_pkg::CMD_ISSUE;
        end else if (pick < issue_pct + 30) begin
          cmd = rttr_pkg::CMD_TICK;
        end else if (pick < issue_pct + 34) begin
          cmd = rttr_pkg::CMD_CLEAR;
        end else begin
          cmd = rttr_pkg::CMD_REPLY;
          live_idx.delete();
          foreach (slot_live[i]) if (slot_live[i]) live_idx.insert(live_idx.size(), i);
          if (live_idx.size() > 0 && $urandom_range(4) != 0) begin
            rid = slot_req_id[live_idx[$urandom_range(live_idx.size() - 1)]];
          end else if ($urandom_range(1) == 0) begin
            rid = id_counter - $urandom_range(0, 3);  // recently freed or never used
          end
          if ($urandom_range(1) == 0) status = '0;
        end
        if ($urandom_range(59) == 0) drain_events();
        send_cmd(cmd, rid, status, 1'b0, no_ev);
      end
    end

    drain_events();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/rttr_pkg.sv
src/rttr_cell.sv
src/rttr_slot_proc.sv
src/request_timeout_retry_tracker_unit.sv
tb/request_timeout_retry_tracker_unit_test.sv
